// ===== design/itoa_pkg.sv =====
// Shared constants, types and state encodings for the signed decimal text core.
package itoa_pkg;

   localparam int MAX_WIDTH   = 32;                      // upper bound on padded text length
   localparam int VALUE_BITS  = 32;                      // input integer width
   localparam int NUM_DIGITS  = 10;                      // decimal digits of a 32-bit magnitude
   localparam int DIGIT_BITS  = $clog2(NUM_DIGITS);      // index of one BCD digit
   localparam int LEN_BITS    = $clog2(NUM_DIGITS + 2);  // text length incl. sign, up to 11
   localparam int PAD_BITS    = $clog2(MAX_WIDTH + 1);   // blank count / clamped width
   localparam int SHIFT_BITS  = $clog2(VALUE_BITS);      // double-dabble step counter
   localparam int FIFO_DEPTH  = 2;
   localparam int CFG_BITS    = 6;                       // min_width register width
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_BLANK = 8'h20;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_MIN_WIDTH = 1'b0;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic                neg;
      logic [LEN_BITS-1:0] len;   // digit count, 1 to NUM_DIGITS
      bcd_type             bcd;
   } conv_entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONV,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_PAD,
      BACK_SIGN,
      BACK_DIGIT
   } back_state_type;

endpackage

// ===== design/signed_int_to_padded_decimal_text_core.sv =====
// Top level: signed 32-bit integer to left-blank-padded decimal ASCII text.
// Order: the first character strobes after 32 double-dabble steps, a queue push, a pop into
// the back's state and the output register; then one character per cycle within a value.
// Pace: the front converter takes no new start until its value is pushed and is slower than
// the back even at full padding, so the front sets the pace; the receiver cannot stall.
// Reset (synchronous, active high) empties the queue, idles both halves and clears min_width.
module signed_int_to_padded_decimal_text_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input item
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [itoa_pkg::VALUE_BITS-1:0] req_value,
   // result items
   output logic                                   rsp_strobe,
   output logic [7:0]                             rsp_character,
   output logic                                   rsp_last,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [itoa_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [itoa_pkg::DATA_BITS-1:0]         pwdata,
   output logic [itoa_pkg::DATA_BITS-1:0]         prdata,
   output logic                                   pready
);

   logic [itoa_pkg::CFG_BITS-1:0] min_width_ff, min_width_in;
   logic                          cfg_write;

   logic                     q_push;
   logic                     q_pop;
   logic                     q_full;
   logic                     q_empty;
   itoa_pkg::conv_entry_type q_wr_data;
   itoa_pkg::conv_entry_type q_rd_data;

   // Register port: pready tied high, one register at byte address 0.
   // Register index sits in paddr[2]; the byte-lane bits are ignored.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready &&
                      (paddr[2] == itoa_pkg::CSR_IDX_MIN_WIDTH);

   always_comb begin
      min_width_in = min_width_ff;
      if (cfg_write) min_width_in = pwdata[itoa_pkg::CFG_BITS-1:0];  // upper bits dropped
   end

   always_comb begin
      if (paddr[2] == itoa_pkg::CSR_IDX_MIN_WIDTH)
         prdata = {{(itoa_pkg::DATA_BITS - itoa_pkg::CFG_BITS){1'b0}}, min_width_ff};
      else
         prdata = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= '0;
      end else begin
         min_width_ff <= min_width_in;
      end
   end

   // Front: sign split and binary-to-BCD, one bit per cycle. It holds its result
   // until the queue has room, so busy also covers a full queue.
   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   // Two-entry queue lets the next conversion run while text is still going out.
   itoa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   // Back: blanks, then '-' for negatives, then digits most significant first.
   // The clamped width is sampled when an entry is taken.
   itoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .min_width     (min_width_ff),
      .q_empty       (q_empty),
      .q_data        (q_rd_data),
      .q_pop         (q_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== design/itoa_front.sv =====
// Front end: takes a value, splits sign and magnitude, converts to BCD by double dabble.
module itoa_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [itoa_pkg::VALUE_BITS-1:0] req_value,
   input  logic                                   q_full,
   output logic                                   q_push,
   output itoa_pkg::conv_entry_type               q_data
);

   itoa_pkg::front_state_type state_ff, state_in;
   logic [itoa_pkg::VALUE_BITS-1:0] mag_ff, mag_in;
   logic [itoa_pkg::SHIFT_BITS-1:0] cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   itoa_pkg::bcd_type               bcd_ff, bcd_in;
   itoa_pkg::bcd_type               adj;
   logic [itoa_pkg::NUM_DIGITS*4-1:0] adj_bits;
   logic [itoa_pkg::LEN_BITS-1:0]   len;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itoa_pkg::FRONT_IDLE: begin
            if (start) state_in = itoa_pkg::FRONT_CONV;
         end
         itoa_pkg::FRONT_CONV: begin
            if (cnt_ff == itoa_pkg::SHIFT_BITS'(itoa_pkg::VALUE_BITS - 1))
               state_in = itoa_pkg::FRONT_PUSH;
         end
         itoa_pkg::FRONT_PUSH: begin
            if (!q_full) state_in = itoa_pkg::FRONT_IDLE;
         end
         default: state_in = itoa_pkg::FRONT_IDLE;
      endcase
   end

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   assign adj_bits = adj;

   // digit count: highest non-zero digit, at least one
   always_comb begin
      len = itoa_pkg::LEN_BITS'(1);
      for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) len = itoa_pkg::LEN_BITS'(i + 1);
      end
   end

   // datapath and outputs
   always_comb begin
      mag_in = mag_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      bcd_in = bcd_ff;
      q_push = 1'b0;
      busy   = (state_ff != itoa_pkg::FRONT_IDLE);
      case (state_ff)
         itoa_pkg::FRONT_IDLE: begin
            if (start) begin
               neg_in = req_value[itoa_pkg::VALUE_BITS-1];
               // two's complement negate also covers the most negative value
               mag_in = req_value[itoa_pkg::VALUE_BITS-1] ?
                        (~req_value + itoa_pkg::VALUE_BITS'(1)) : req_value;
               cnt_in = '0;
               bcd_in = '0;
            end
         end
         itoa_pkg::FRONT_CONV: begin
            bcd_in = {adj_bits[itoa_pkg::NUM_DIGITS*4-2:0], mag_ff[itoa_pkg::VALUE_BITS-1]};
            mag_in = {mag_ff[itoa_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + itoa_pkg::SHIFT_BITS'(1);
         end
         itoa_pkg::FRONT_PUSH: begin
            q_push = !q_full;
         end
         default: ;
      endcase
   end

   assign q_data.neg = neg_ff;
   assign q_data.len = len;
   assign q_data.bcd = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itoa_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      bcd_ff <= bcd_in;
   end

endmodule

// ===== design/itoa_fifo.sv =====
// Short queue of converted values between front and back.
module itoa_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  itoa_pkg::conv_entry_type push_data,
   output logic                     full,
   input  logic                     pop,
   output itoa_pkg::conv_entry_type pop_data,
   output logic                     empty
);

   localparam int PtrBits = $clog2(itoa_pkg::FIFO_DEPTH);
   localparam int CntBits = $clog2(itoa_pkg::FIFO_DEPTH + 1);

   itoa_pkg::conv_entry_type entry_ff [itoa_pkg::FIFO_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;

   assign full     = (count_ff == CntBits'(itoa_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(itoa_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(itoa_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) count_in = count_ff + CntBits'(1);
      else if (pop && !push) count_in = count_ff - CntBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue popped while empty");
`endif

endmodule

// ===== design/itoa_back.sv =====
// Back end: emits blanks, sign and digits of one queued value, one character per cycle.
module itoa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [itoa_pkg::CFG_BITS-1:0]     min_width,
   input  logic                              q_empty,
   input  itoa_pkg::conv_entry_type          q_data,
   output logic                              q_pop,
   output logic                              rsp_strobe,
   output logic [7:0]                        rsp_character,
   output logic                              rsp_last
);

   itoa_pkg::back_state_type state_ff, state_in;
   logic [itoa_pkg::PAD_BITS-1:0]   pad_ff, pad_in;
   logic                            neg_ff, neg_in;
   logic [itoa_pkg::DIGIT_BITS-1:0] idx_ff, idx_in;
   itoa_pkg::bcd_type               bcd_ff, bcd_in;
   logic                            strobe_ff, strobe_in;
   logic [7:0]                      char_ff, char_in;
   logic                            last_ff, last_in;

   logic [itoa_pkg::PAD_BITS-1:0]   width;
   logic [itoa_pkg::LEN_BITS-1:0]   text_len;
   logic [itoa_pkg::PAD_BITS-1:0]   pad_new;

   // clamp the width and work out the blank count of the head entry
   always_comb begin
      if (int'(min_width) > itoa_pkg::MAX_WIDTH) width = itoa_pkg::PAD_BITS'(itoa_pkg::MAX_WIDTH);
      else width = itoa_pkg::PAD_BITS'(min_width);
      text_len = q_data.len + itoa_pkg::LEN_BITS'(q_data.neg);
      if (int'(width) > int'(text_len))
         pad_new = itoa_pkg::PAD_BITS'(int'(width) - int'(text_len));
      else
         pad_new = '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itoa_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               if (pad_new != '0) state_in = itoa_pkg::BACK_PAD;
               else if (q_data.neg) state_in = itoa_pkg::BACK_SIGN;
               else state_in = itoa_pkg::BACK_DIGIT;
            end
         end
         itoa_pkg::BACK_PAD: begin
            if (pad_ff == itoa_pkg::PAD_BITS'(1))
               state_in = neg_ff ? itoa_pkg::BACK_SIGN : itoa_pkg::BACK_DIGIT;
         end
         itoa_pkg::BACK_SIGN: state_in = itoa_pkg::BACK_DIGIT;
         itoa_pkg::BACK_DIGIT: begin
            if (idx_ff == '0) state_in = itoa_pkg::BACK_IDLE;
         end
         default: state_in = itoa_pkg::BACK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pad_in    = pad_ff;
      neg_in    = neg_ff;
      idx_in    = idx_ff;
      bcd_in    = bcd_ff;
      q_pop     = 1'b0;
      strobe_in = 1'b0;
      char_in   = itoa_pkg::CHAR_BLANK;
      last_in   = 1'b0;
      case (state_ff)
         itoa_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               pad_in = pad_new;
               neg_in = q_data.neg;
               idx_in = itoa_pkg::DIGIT_BITS'(q_data.len - itoa_pkg::LEN_BITS'(1));
               bcd_in = q_data.bcd;
            end
         end
         itoa_pkg::BACK_PAD: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_BLANK;
            pad_in    = pad_ff - itoa_pkg::PAD_BITS'(1);
         end
         itoa_pkg::BACK_SIGN: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_MINUS;
         end
         itoa_pkg::BACK_DIGIT: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_ZERO + {4'd0, bcd_ff[idx_ff]};
            last_in   = (idx_ff == '0);
            idx_in    = idx_ff - itoa_pkg::DIGIT_BITS'(1);
         end
         default: ;
      endcase
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= itoa_pkg::BACK_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
      pad_ff  <= pad_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
   end

`ifndef NO_ASSERTIONS
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without a character");
   a_pop_leads_text: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> ##1 rsp_strobe)
      else $error("no character after taking an entry");
`endif

endmodule
